@@ rtl/stwr_pkg.sv @@
// Package with the sequencer step type, the result type and fixed widths of the two-wire word reader.
package stwr_pkg;

    localparam int unsigned PHASE_W   = 16;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BITCNT_W  = 4;
    localparam int unsigned IN_DATA_W = 16;
    localparam int unsigned OUT_DATA_W = 24;
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'd0,
        ST_S1      = 5'd1,
        ST_S2      = 5'd2,
        ST_S3      = 5'd3,
        ST_S4      = 5'd4,
        ST_S5      = 5'd5,
        ST_CSET    = 5'd6,
        ST_CHIGH   = 5'd7,
        ST_CLOW    = 5'd8,
        ST_AHIGH   = 5'd9,
        ST_ASAMPLE = 5'd10,
        ST_WREL    = 5'd11,
        ST_WLOW    = 5'd12,
        ST_RHIGH   = 5'd13,
        ST_RSAMPLE = 5'd14,
        ST_KHIGH   = 5'd15,
        ST_KLOW    = 5'd16,
        ST_RGAP    = 5'd17,
        ST_FINISH  = 5'd18
    } t_step;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              no_ack;
        logic              done_res;
        logic              busy_res;
        logic              data_pull_low;
        logic              clock_out;
    } t_result;

endpackage

@@ rtl/sensor_two_wire_word_reader.sv @@
// Top level of the two-wire sensor word reader: tick-driven bit sequencer.
//
// Every input beat on the slave stream is one tick of the bit sequencer. It
// carries the start request, the command byte and the sampled data line level
// in tdata, and the opcode in tuser. Every accepted beat yields exactly one
// result beat on the master stream with the clock and data-pull line levels,
// the busy and done flags, the no-acknowledge flag and the received word.
// The result of a tick appears in the output register in the cycle after its
// beat is accepted. One beat is taken every cycle: the step logic is a single
// pass from the state registers and the input beat to the output register, so
// the only limit on throughput is the receiver taking results.
// When the receiver stalls, the result is held in the output register and a
// new input beat is taken only in a cycle where that register empties.
// The configuration channel writes phase_ticks, the number of ticks between
// line changes; it is always ready and should only be written while idle.
// A phase_ticks of zero behaves as one.
// Synchronous active-low reset puts the sequencer in its idle step with the
// clock low, the data line released, the received word cleared and
// phase_ticks at one; the output register is emptied.
module sensor_two_wire_word_reader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel: phase_ticks.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [stwr_pkg::PHASE_W-1:0] i_cfg_data,
    // Input tick stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: start_req[0], command[8:1], data_in[9], zero pad [15:10].
    input  logic [stwr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: opcode[0].
    input  logic        s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: clock_out[0], data_pull_low[1], busy_res[2],
    // done_res[3], no_ack[4], word[20:5], zero pad [23:21].
    output logic [stwr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import stwr_pkg::*;

    // Configuration register.
    logic [PHASE_W-1:0]  r_phase;

    // Sequencer state.
    t_step               r_step, n_step;
    logic [BITCNT_W-1:0] r_bit_count, n_bit_count;
    logic [BYTE_W-1:0]   r_shift, n_shift;
    logic                r_byte_index, n_byte_index;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [PHASE_W-1:0]  r_delay, n_delay;
    logic                r_opcode, n_opcode;
    logic                r_clock, n_clock;
    logic                r_pull, n_pull;

    // Output register.
    logic                r_out_valid;
    t_result             r_out, n_out;

    logic                in_beat;
    logic                in_start;
    logic [BYTE_W-1:0]   in_command;
    logic                in_data;
    logic [PHASE_W-1:0]  phase_load;
    logic [BITCNT_W-1:0] bit_count_inc;
    logic [BYTE_W-1:0]   shift_up;
    logic [BYTE_W-1:0]   shift_in;
    logic                done_flag;
    logic                nack_flag;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign in_start   = s_axis_tdata[0];
    assign in_command = s_axis_tdata[8:1];
    assign in_data    = s_axis_tdata[9];

    // Reload value of the delay counter: the tick making a change is the
    // first tick of its phase, and zero acts as one.
    assign phase_load    = (r_phase == '0) ? '0 : r_phase - 1'b1;
    assign bit_count_inc = r_bit_count + 1'b1;
    assign shift_up      = {r_shift[BYTE_W-2:0], 1'b0};
    assign shift_in      = {r_shift[BYTE_W-2:0], in_data};

    // Next-state logic for one tick.
    always_comb begin
        n_step       = r_step;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_byte_index = r_byte_index;
        n_word       = r_word;
        n_delay      = r_delay;
        n_opcode     = r_opcode;
        n_clock      = r_clock;
        n_pull       = r_pull;
        done_flag    = 1'b0;
        nack_flag    = 1'b0;

        if (r_step != ST_IDLE && r_delay != '0) begin
            n_delay = r_delay - 1'b1;
        end else begin
            unique case (r_step)
                ST_IDLE: begin
                    if (in_start) begin
                        n_opcode     = s_axis_tuser;
                        n_shift      = in_command;
                        n_bit_count  = '0;
                        n_byte_index = 1'b0;
                        n_word       = '0;
                        n_clock      = 1'b1;
                        n_delay      = phase_load;
                        n_step       = ST_S1;
                    end
                end
                ST_S1: begin
                    n_pull = 1'b1; n_delay = phase_load; n_step = ST_S2;
                end
                ST_S2: begin
                    n_clock = 1'b0; n_delay = phase_load; n_step = ST_S3;
                end
                ST_S3: begin
                    n_clock = 1'b1; n_delay = phase_load; n_step = ST_S4;
                end
                ST_S4: begin
                    n_pull = 1'b0; n_delay = phase_load; n_step = ST_S5;
                end
                ST_S5: begin
                    n_clock = 1'b0; n_delay = phase_load; n_step = ST_CSET;
                end
                ST_CSET: begin
                    n_pull  = !r_shift[BYTE_W-1];
                    n_delay = phase_load;
                    n_step  = ST_CHIGH;
                end
                ST_CHIGH: begin
                    n_clock = 1'b1; n_delay = phase_load; n_step = ST_CLOW;
                end
                ST_CLOW: begin
                    n_clock     = 1'b0;
                    n_shift     = shift_up;
                    n_bit_count = bit_count_inc;
                    n_delay     = phase_load;
                    if (bit_count_inc < BITS_PER_BYTE) begin
                        n_pull = !shift_up[BYTE_W-1];
                        n_step = ST_CHIGH;
                    end else begin
                        n_pull = 1'b0;
                        n_step = ST_AHIGH;
                    end
                end
                ST_AHIGH: begin
                    n_clock = 1'b1; n_delay = phase_load; n_step = ST_ASAMPLE;
                end
                ST_ASAMPLE: begin
                    n_clock = 1'b0;
                    if (in_data) begin
                        done_flag = 1'b1;
                        nack_flag = 1'b1;
                        n_step    = ST_IDLE;
                    end else begin
                        n_step = ST_WREL;
                    end
                end
                ST_WREL: begin
                    if (in_data) begin
                        if (r_opcode) begin
                            done_flag = 1'b1;
                            n_step    = ST_IDLE;
                        end else begin
                            n_step = ST_WLOW;
                        end
                    end
                end
                ST_WLOW: begin
                    if (!in_data) begin
                        n_bit_count = '0;
                        n_shift     = '0;
                        n_delay     = phase_load;
                        n_step      = ST_RHIGH;
                    end
                end
                ST_RGAP: begin
                    n_bit_count = '0;
                    n_shift     = '0;
                    n_delay     = phase_load;
                    n_step      = ST_RHIGH;
                end
                ST_RHIGH: begin
                    n_clock = 1'b1; n_delay = phase_load; n_step = ST_RSAMPLE;
                end
                ST_RSAMPLE: begin
                    n_shift     = shift_in;
                    n_clock     = 1'b0;
                    n_bit_count = bit_count_inc;
                    n_delay     = phase_load;
                    if (bit_count_inc < BITS_PER_BYTE) begin
                        n_step = ST_RHIGH;
                    end else begin
                        // The first byte lands in the upper half and is
                        // acknowledged; the second fills the lower half.
                        if (!r_byte_index) begin
                            n_word = {shift_in, {BYTE_W{1'b0}}};
                            n_pull = 1'b1;
                        end else begin
                            n_word = {r_word[WORD_W-1:BYTE_W], shift_in};
                        end
                        n_step = ST_KHIGH;
                    end
                end
                ST_KHIGH: begin
                    n_clock = 1'b1; n_delay = phase_load; n_step = ST_KLOW;
                end
                ST_KLOW: begin
                    n_clock = 1'b0;
                    n_pull  = 1'b0;
                    n_delay = phase_load;
                    if (!r_byte_index) begin
                        n_byte_index = 1'b1;
                        n_step       = ST_RGAP;
                    end else begin
                        n_step = ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    done_flag = 1'b1;
                    n_step    = ST_IDLE;
                end
                default: begin
                    n_step  = ST_IDLE;
                    n_clock = 1'b0;
                    n_pull  = 1'b0;
                end
            endcase
        end
    end

    // Result fields of the tick, taken after its changes.
    always_comb begin
        n_out.clock_out     = n_clock;
        n_out.data_pull_low = n_pull;
        n_out.busy_res      = (n_step != ST_IDLE);
        n_out.done_res      = done_flag;
        n_out.no_ack        = nack_flag;
        n_out.word          = n_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PHASE_W'(1);
            r_step       <= ST_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_byte_index <= 1'b0;
            r_word       <= '0;
            r_delay      <= '0;
            r_opcode     <= 1'b0;
            r_clock      <= 1'b0;
            r_pull       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_phase <= i_cfg_data;
            end
            if (in_beat) begin
                r_step       <= n_step;
                r_bit_count  <= n_bit_count;
                r_shift      <= n_shift;
                r_byte_index <= n_byte_index;
                r_word       <= n_word;
                r_delay      <= n_delay;
                r_opcode     <= n_opcode;
                r_clock      <= n_clock;
                r_pull       <= n_pull;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is only looked at with its valid.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out};

    // The delay counter only runs outside the idle step.
    a_idle_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_IDLE) |-> (r_delay == '0))
        else $error("delay counter nonzero while idle");

    // The bit counter never passes one full byte.
    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= BITS_PER_BYTE)
        else $error("bit counter beyond a byte");

    // A done beat always reports the sequencer back at idle.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done reported while still busy");

    // No-acknowledge is only flagged together with done.
    a_nack_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.no_ack) |-> r_out.done_res)
        else $error("no_ack without done");

    // A stalled result stays in the output register unchanged.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result lost or changed");

endmodule
